// File: rtl/euclidean_distance_matrix_graph_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distance matrix graph unit
// Each macro expands to one labeled concurrent assertion on clk, disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_MATRIX_GRAPH_UNIT_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_MATRIX_GRAPH_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDMG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EDMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/edmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmg_pkg
// Shared types, codes and sizes of the distance matrix graph unit.
// ----------------------------------------------------------------------------
package edmg_pkg;

	localparam int unsigned EDMG_MAX_VERTICES = 64;
	localparam int unsigned EDMG_COORD_WIDTH  = 24;

	localparam int ID_W    = 7;
	localparam int FCRD_W  = 24;
	localparam int DIST_W  = 25;
	localparam int OP_W    = 2;
	localparam int STS_W   = 3;
	localparam int SUM_W   = 64;
	localparam int ROOT_W  = 32;

	localparam logic [ROOT_W-1:0] DIST_MAX = ROOT_W'(32'h01FF_FFFF);

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_EDIT   = 2'd3;

	localparam logic [STS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STS_W-1:0] STS_BAD_ID    = 3'd1;
	localparam logic [STS_W-1:0] STS_EXISTS    = 3'd2;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd3;
	localparam logic [STS_W-1:0] STS_NO_EDGE   = 3'd4;
	localparam logic [STS_W-1:0] STS_BAD_VALUE = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ID_W-1:0]   vertex_a;
		logic [ID_W-1:0]   vertex_b;
		logic [FCRD_W-1:0] coord_x;
		logic [FCRD_W-1:0] coord_y;
		logic [DIST_W-1:0] new_distance;
	} edmg_req_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic              edge_exists;
		logic [DIST_W-1:0] edge_distance;
	} edmg_rsp_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_READ,
		FSM_WALK,
		FSM_DRAIN,
		FSM_DONE
	} edmg_state_t;

	typedef struct packed {
		logic capture;
		logic eval_check;
		logic eval_read;
		logic walk_issue;
		logic out_load;
	} edmg_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            check_ok;
		logic            walk_last;
		logic            pipe_busy;
	} edmg_sts_t;

endpackage

// File: rtl/euclidean_distance_matrix_graph_unit.sv
`timescale 1ns / 1ps
// Query and edit read the matrix before their result beat is loaded, remove and
// every failed check load it straight after the check, and add after the walk.
// The add latency is set by the walk over all vertex slots, one per cycle,
// feeding a 36-stage distance pipeline (read, 3 arithmetic, 32 root stages).
// One request is in work at a time; a finished beat waits in an output register.
// Reset clears the vertex valid bits at once; no memory clearing pass is run.
// ----------------------------------------------------------------------------
// euclidean_distance_matrix_graph_unit
// Complete Euclidean graph store: add and remove vertices, query and edit edges.
// ----------------------------------------------------------------------------
module euclidean_distance_matrix_graph_unit import edmg_pkg::*; #(
	parameter int unsigned MAX_VERTICES = EDMG_MAX_VERTICES,
	parameter int unsigned COORD_WIDTH  = EDMG_COORD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  edmg_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output edmg_rsp_t rsp
);

	// The controller only sequences; every check, store and the distance
	// arithmetic live in the datapath. The two talk through cmd and sts.
	edmg_cmd_t cmd;
	edmg_sts_t sts;

	// Sequencer: idle, check, then either a matrix read (query and edit),
	// a walk over all slots followed by a pipeline drain (add), or straight
	// to the result for remove and failures.
	edmg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The matrix keeps one entry per unordered vertex pair, so an add writes
	// one entry per other live vertex and an edit writes a single entry. A removed
	// vertex needs no matrix work: its entries are rewritten before any
	// later read can reach them.
	edmg_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

// File: rtl/edmg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmg_ctrl
// Sequencer: steps one request through check, read or walk, and the result.
// ----------------------------------------------------------------------------
module edmg_ctrl import edmg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  edmg_sts_t sts,
	output edmg_cmd_t cmd
);

	edmg_state_t state_q, state_nx;
	logic        rsp_valid_q;
	logic        slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (req_valid) state_nx = FSM_CHECK;
			end
			FSM_CHECK: begin
				if (!sts.check_ok) begin
					state_nx = FSM_DONE;
				end else if (sts.op == OP_ADD) begin
					state_nx = FSM_WALK;
				end else if (sts.op == OP_REMOVE) begin
					state_nx = FSM_DONE;
				end else begin
					state_nx = FSM_READ;
				end
			end
			FSM_READ:  state_nx = FSM_DONE;
			FSM_WALK: begin
				if (sts.walk_last) state_nx = FSM_DRAIN;
			end
			FSM_DRAIN: begin
				if (!sts.pipe_busy) state_nx = FSM_DONE;
			end
			FSM_DONE: begin
				if (slot_free) state_nx = FSM_IDLE;
			end
			default:   state_nx = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			FSM_CHECK: cmd.eval_check = 1'b1;
			FSM_READ:  cmd.eval_read  = 1'b1;
			FSM_WALK:  cmd.walk_issue = 1'b1;
			FSM_DONE:  cmd.out_load   = slot_free;
			default:   cmd = '0;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/edmg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmg_sqrt
// Pipelined truncating integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module edmg_sqrt import edmg_pkg::*; #(
	parameter int TAG_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  in_value,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output logic [TAG_W-1:0]  out_tag,
	output logic              busy
);

	localparam int STAGES = SUM_W / 2;

	logic [STAGES-1:0] vld_s;
	logic [SUM_W-1:0]  rem_s [STAGES];
	logic [SUM_W-1:0]  res_s [STAGES];
	logic [TAG_W-1:0]  tag_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [SUM_W-1:0] BITK = SUM_W'(1) << (SUM_W - 2 - 2 * k);
		logic             cur_vld;
		logic [SUM_W-1:0] cur_rem, cur_res, trial;
		logic [TAG_W-1:0] cur_tag;
		logic             take;

		if (k == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_rem = in_value;
			assign cur_res = '0;
			assign cur_tag = in_tag;
		end else begin : g_next
			assign cur_vld = vld_s[k-1];
			assign cur_rem = rem_s[k-1];
			assign cur_res = res_s[k-1];
			assign cur_tag = tag_s[k-1];
		end

		assign trial = cur_res + BITK;
		assign take  = cur_rem >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? cur_rem - trial : cur_rem;
			res_s[k] <= take ? (cur_res >> 1) + BITK : cur_res >> 1;
			tag_s[k] <= cur_tag;
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_root  = ROOT_W'(res_s[STAGES-1]);
	assign out_tag   = tag_s[STAGES-1];
	assign busy      = |vld_s;

endmodule

// File: rtl/edmg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmg_dp
// Datapath: request registers, checks, vertex store, distance matrix and
// the distance pipeline.
// ----------------------------------------------------------------------------
module edmg_dp import edmg_pkg::*; #(
	parameter int unsigned MAX_VERTICES = EDMG_MAX_VERTICES,
	parameter int unsigned COORD_WIDTH  = EDMG_COORD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  edmg_req_t req,
	input  edmg_cmd_t cmd,
	output edmg_sts_t sts,
	output edmg_rsp_t rsp
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int AW = 2 * IW;
	localparam int MD = 1 << AW;
	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW;

	// Latched request.
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   ida_q, idb_q;
	logic [CW-1:0]     cx_q, cy_q;
	logic [DIST_W-1:0] nd_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req.operation;
			ida_q <= req.vertex_a;
			idb_q <= req.vertex_b;
			cx_q  <= CW'(req.coord_x);
			cy_q  <= CW'(req.coord_y);
			nd_q  <= req.new_distance;
		end
	end

	logic [MAX_VERTICES-1:0] valid_q;
	logic [IW-1:0]           a_idx, b_idx, lo_ab, hi_ab;
	logic                    a_bad, b_bad, a_valid, b_valid;
	logic [STS_W-1:0]        chk_st;

	assign a_bad   = (ida_q == '0) || (32'(ida_q) > MAX_VERTICES);
	assign b_bad   = (idb_q == '0) || (32'(idb_q) > MAX_VERTICES);
	assign a_idx   = IW'(ida_q - ID_W'(1));
	assign b_idx   = IW'(idb_q - ID_W'(1));
	assign a_valid = !a_bad && valid_q[a_idx];
	assign b_valid = !b_bad && valid_q[b_idx];
	assign lo_ab   = (a_idx < b_idx) ? a_idx : b_idx;
	assign hi_ab   = (a_idx < b_idx) ? b_idx : a_idx;

	always_comb begin
		case (op_q)
			OP_ADD: begin
				if (a_bad)                         chk_st = STS_BAD_ID;
				else if (a_valid)                  chk_st = STS_EXISTS;
				else if (cx_q == '0 || cy_q == '0) chk_st = STS_BAD_VALUE;
				else                               chk_st = STS_OK;
			end
			OP_REMOVE: begin
				if (a_bad)         chk_st = STS_BAD_ID;
				else if (!a_valid) chk_st = STS_NOT_FOUND;
				else               chk_st = STS_OK;
			end
			default: begin
				if (a_bad)         chk_st = STS_BAD_ID;
				else if (!a_valid) chk_st = STS_NOT_FOUND;
				else if (b_bad)    chk_st = STS_BAD_ID;
				else if (!b_valid) chk_st = STS_NOT_FOUND;
				else               chk_st = STS_OK;
			end
		endcase
	end

	logic check_ok, commit_add, commit_rm;
	assign check_ok   = chk_st == STS_OK;
	assign commit_add = cmd.eval_check && check_ok && op_q == OP_ADD;
	assign commit_rm  = cmd.eval_check && check_ok && op_q == OP_REMOVE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (commit_add) begin
			valid_q[a_idx] <= 1'b1;
		end else if (commit_rm) begin
			valid_q[a_idx] <= 1'b0;
		end
	end

	// Coordinate store, one read port for the walk.
	logic [CW-1:0] x_mem [MAX_VERTICES];
	logic [CW-1:0] y_mem [MAX_VERTICES];
	logic [IW-1:0] wcnt_q;
	logic          issue_ok;

	assign issue_ok = cmd.walk_issue && valid_q[wcnt_q] && (wcnt_q != a_idx);

	always_ff @(posedge clk) begin
		if (commit_add) begin
			x_mem[a_idx] <= cx_q;
			y_mem[a_idx] <= cy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_check) begin
			wcnt_q <= '0;
		end else if (cmd.walk_issue) begin
			wcnt_q <= wcnt_q + IW'(1);
		end
	end

	// Distance pipeline front end.
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [IW-1:0] tag_s1, tag_s2, tag_s3, tag_s4;
	logic [CW-1:0] x_s1, y_s1, dx_s2, dy_s2;
	logic [PW-1:0] sx_s3, sy_s3;
	logic [SUM_W-1:0] sum_s4;
	logic [PW:0]   sum_w;
	logic          sum_sat;

	assign sum_w   = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign sum_sat = (PW + 1 > SUM_W) && sum_w[PW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue_ok;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= x_mem[wcnt_q];
		y_s1   <= y_mem[wcnt_q];
		tag_s1 <= wcnt_q;
		dx_s2  <= (x_s1 > cx_q) ? x_s1 - cx_q : cx_q - x_s1;
		dy_s2  <= (y_s1 > cy_q) ? y_s1 - cy_q : cy_q - y_s1;
		tag_s2 <= tag_s1;
		sx_s3  <= PW'(dx_s2) * PW'(dx_s2);
		sy_s3  <= PW'(dy_s2) * PW'(dy_s2);
		tag_s3 <= tag_s2;
		sum_s4 <= sum_sat ? '1 : SUM_W'(sum_w);
		tag_s4 <= tag_s3;
	end

	logic              sq_valid, sq_busy;
	logic [ROOT_W-1:0] sq_root;
	logic [IW-1:0]     sq_tag;

	edmg_sqrt #(.TAG_W(IW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_value (sum_s4),
		.in_tag   (tag_s4),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_tag  (sq_tag),
		.busy     (sq_busy)
	);

	logic [DIST_W-1:0] walk_dist;
	logic [AW-1:0]     walk_addr;

	assign walk_dist = (sq_root > DIST_MAX) ? '1 : sq_root[DIST_W-1:0];
	assign walk_addr = (sq_tag < a_idx) ? {sq_tag, a_idx} : {a_idx, sq_tag};

	// Distance matrix: only the entry with the lower index first is kept.
	logic [DIST_W-1:0] mtx [MD];
	logic [DIST_W-1:0] mtx_rd_q;
	logic              has_edge, edit_wr;
	logic [STS_W-1:0]  rd_st;

	assign has_edge = (a_idx != b_idx) && (mtx_rd_q != '0);
	assign edit_wr  = cmd.eval_read && op_q == OP_EDIT && has_edge && nd_q != '0;

	always_comb begin
		if (op_q == OP_QUERY)   rd_st = STS_OK;
		else if (!has_edge)     rd_st = STS_NO_EDGE;
		else if (nd_q == '0)    rd_st = STS_BAD_VALUE;
		else                    rd_st = STS_OK;
	end

	always_ff @(posedge clk) begin
		if (edit_wr) begin
			mtx[{lo_ab, hi_ab}] <= nd_q;
		end else if (sq_valid) begin
			mtx[walk_addr] <= walk_dist;
		end
		mtx_rd_q <= mtx[{lo_ab, hi_ab}];
	end

	// Working result and the output register.
	edmg_rsp_t res_q, rsp_q;
	logic      q_edge;

	assign q_edge = op_q == OP_QUERY && has_edge;

	always_ff @(posedge clk) begin
		if (cmd.eval_check) begin
			res_q.status        <= chk_st;
			res_q.edge_exists   <= 1'b0;
			res_q.edge_distance <= '0;
		end else if (cmd.eval_read) begin
			res_q.status        <= rd_st;
			res_q.edge_exists   <= q_edge;
			res_q.edge_distance <= q_edge ? mtx_rd_q : '0;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp           = rsp_q;
	assign sts.op        = op_q;
	assign sts.check_ok  = check_ok;
	assign sts.walk_last = wcnt_q == IW'(MAX_VERTICES - 1);
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || sq_busy;

endmodule

// File: rtl/edmg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmg_checker
// Port-level assertions for the distance matrix graph unit.
// ----------------------------------------------------------------------------
`include "euclidean_distance_matrix_graph_unit_defines.svh"

module edmg_checker import edmg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input edmg_rsp_t rsp
);

	`EDMG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
	`EDMG_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "second request taken while busy")
	`EDMG_ASSERT_SAME(a_edge_ok, rsp_valid && rsp.edge_exists, rsp.status == STS_OK, "edge flag on failed status")
	`EDMG_ASSERT_SAME(a_no_edge_zero, rsp_valid && !rsp.edge_exists, rsp.edge_distance == '0, "distance without edge")
	`EDMG_ASSERT_SAME(a_edge_nonzero, rsp_valid && rsp.edge_exists, rsp.edge_distance != '0, "edge with zero distance")

endmodule

bind euclidean_distance_matrix_graph_unit edmg_checker u_edmg_checker (.*);

// File: tb/euclidean_distance_matrix_graph_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_matrix_graph_unit_checker
// Watches both channels, keeps its own graph store and predicts each response.
// ----------------------------------------------------------------------------
module euclidean_distance_matrix_graph_unit_checker import edmg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  edmg_req_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  edmg_rsp_t rsp,
	output int        fail_count,
	output int        pending
);

	localparam int NV = EDMG_MAX_VERTICES;

	logic              vert_live [NV];
	logic [FCRD_W-1:0] vert_x [NV];
	logic [FCRD_W-1:0] vert_y [NV];
	logic [DIST_W-1:0] dist_mat [NV*NV];
	edmg_rsp_t         rsp_queue [$];

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [DIST_W-1:0] span(logic [FCRD_W-1:0] x1, logic [FCRD_W-1:0] y1,
			logic [FCRD_W-1:0] x2, logic [FCRD_W-1:0] y2);
		logic [63:0] dx, dy, sum, r;
		dx = (x1 > x2) ? x1 - x2 : x2 - x1;
		dy = (y1 > y2) ? y1 - y2 : y2 - y1;
		sum = dx * dx + dy * dy;
		r = int_root(sum);
		if (r > 64'h1FF_FFFF)
			r = 64'h1FF_FFFF;
		return r[DIST_W-1:0];
	endfunction

	function automatic logic [STS_W-1:0] id_check(logic [ID_W-1:0] id);
		if (id == 0 || id > NV)
			return STS_BAD_ID;
		if (!vert_live[id-1])
			return STS_NOT_FOUND;
		return STS_OK;
	endfunction

	task automatic apply_request(edmg_req_t q);
		edmg_rsp_t r;
		int a, b;
		logic [DIST_W-1:0] d;
		r = '0;
		a = q.vertex_a - 1;
		b = q.vertex_b - 1;
		if (q.operation == OP_ADD) begin
			if (q.vertex_a == 0 || q.vertex_a > NV)
				r.status = STS_BAD_ID;
			else if (vert_live[a])
				r.status = STS_EXISTS;
			else if (q.coord_x == 0 || q.coord_y == 0)
				r.status = STS_BAD_VALUE;
			else begin
				vert_x[a] = q.coord_x;
				vert_y[a] = q.coord_y;
				vert_live[a] = 1'b1;
				for (int i = 0; i < NV; i++) begin
					if (!vert_live[i])
						continue;
					if (i == a)
						dist_mat[a*NV+a] = '0;
					else begin
						d = span(vert_x[i], vert_y[i], q.coord_x, q.coord_y);
						dist_mat[i*NV+a] = d;
						dist_mat[a*NV+i] = d;
					end
				end
			end
		end else if (q.operation == OP_REMOVE) begin
			r.status = id_check(q.vertex_a);
			if (r.status == STS_OK) begin
				vert_live[a] = 1'b0;
				for (int i = 0; i < NV; i++) begin
					dist_mat[i*NV+a] = '0;
					dist_mat[a*NV+i] = '0;
				end
			end
		end else begin
			r.status = id_check(q.vertex_a);
			if (r.status == STS_OK)
				r.status = id_check(q.vertex_b);
			if (r.status == STS_OK) begin
				d = dist_mat[a*NV+b];
				if (q.operation == OP_QUERY) begin
					if (a != b && d != 0) begin
						r.edge_exists = 1'b1;
						r.edge_distance = d;
					end
				end else if (a == b || d == 0)
					r.status = STS_NO_EDGE;
				else if (q.new_distance == 0)
					r.status = STS_BAD_VALUE;
				else begin
					dist_mat[a*NV+b] = q.new_distance;
					dist_mat[b*NV+a] = q.new_distance;
				end
			end
		end
		rsp_queue.push_back(r);
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		for (int i = 0; i < NV; i++)
			vert_live[i] = 1'b0;
		for (int i = 0; i < NV*NV; i++)
			dist_mat[i] = '0;
	end

	always @(posedge clk) begin
		edmg_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_queue.size() == 0) begin
					$error("response beat with nothing expected");
					fail_count++;
				end else begin
					want = rsp_queue.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.edge_exists !== want.edge_exists) begin
						$error("edge_exists: expected %0d, got %0d",
							want.edge_exists, rsp.edge_exists);
						fail_count++;
					end
					if (rsp.edge_distance !== want.edge_distance) begin
						$error("edge_distance: expected %0h, got %0h",
							want.edge_distance, rsp.edge_distance);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				apply_request(req);
			pending = rsp_queue.size();
		end
	end

endmodule

// File: tb/euclidean_distance_matrix_graph_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_matrix_graph_unit_tb
// Drives directed and random graph operations through the unit under four
// idling phases; the checker beside the block predicts and compares beats.
// ----------------------------------------------------------------------------
module euclidean_distance_matrix_graph_unit_tb import edmg_pkg::*;;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	edmg_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	edmg_rsp_t rsp;
	int        fail_count;
	int        pending;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int        send_idle_pct;
	int        recv_stall_pct;
	int        sent_beats;

	euclidean_distance_matrix_graph_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	euclidean_distance_matrix_graph_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// The receiver stalls at random; the decision is made at each falling edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Sends one request beat: optional idle gaps with valid low, then valid
	// held until accepted. Valid stays high after acceptance only until the
	// next falling edge, where the next beat or an idle cycle replaces it.
	task automatic send_beat(edmg_req_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
		sent_beats++;
	endtask

	function automatic edmg_req_t make_req(logic [OP_W-1:0] op, int a, int b,
			logic [FCRD_W-1:0] x, logic [FCRD_W-1:0] y, logic [DIST_W-1:0] nd);
		edmg_req_t q;
		q.operation = op;
		q.vertex_a = ID_W'(a);
		q.vertex_b = ID_W'(b);
		q.coord_x = x;
		q.coord_y = y;
		q.new_distance = nd;
		return q;
	endfunction

	// Mostly valid ids among a small pool so that adds, edges and removals
	// meet each other; some ids are out of range to reach the bad id path.
	function automatic int pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return 0;
		if (r < 8)
			return $urandom_range(127, 65);
		if (r < 70)
			return $urandom_range(16, 1);
		return $urandom_range(64, 1);
	endfunction

	function automatic logic [FCRD_W-1:0] pick_coord();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return FCRD_W'($urandom_range(4096, 1));
		return FCRD_W'($urandom());
	endfunction

	function automatic edmg_req_t random_req();
		logic [DIST_W-1:0] nd;
		nd = ($urandom_range(15) == 0) ? '0 : DIST_W'($urandom());
		return make_req(OP_W'($urandom_range(3)), pick_id(), pick_id(),
			pick_coord(), pick_coord(), nd);
	endfunction

	// Wait until the checker holds no expectation; the unit has one request in
	// work at a time, so an empty queue means it is idle.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	initial begin
		int phase_idle [4];
		int phase_stall [4];
		phase_idle = '{0, 45, 0, 19};
		phase_stall = '{0, 0, 45, 19};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent_beats = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: extremes of coordinates and ids, each failure status,
		// coincident vertices, the same vertex twice, and an edit to zero.
		send_beat(make_req(OP_QUERY, 1, 2, 0, 0, 0));
		send_beat(make_req(OP_ADD, 0, 0, 1, 1, 0));
		send_beat(make_req(OP_ADD, 127, 0, 1, 1, 0));
		send_beat(make_req(OP_ADD, 1, 0, 0, 5, 0));
		send_beat(make_req(OP_ADD, 1, 0, 5, 0, 0));
		send_beat(make_req(OP_ADD, 1, 0, 1, 1, 0));
		send_beat(make_req(OP_ADD, 1, 0, 9, 9, 0));
		send_beat(make_req(OP_ADD, 64, 0, '1, '1, 0));
		send_beat(make_req(OP_ADD, 2, 0, 1, 1, 0));
		send_beat(make_req(OP_QUERY, 1, 64, 0, 0, 0));
		send_beat(make_req(OP_QUERY, 1, 2, 0, 0, 0));
		send_beat(make_req(OP_QUERY, 1, 1, 0, 0, 0));
		send_beat(make_req(OP_EDIT, 1, 2, 0, 0, 7));
		send_beat(make_req(OP_EDIT, 1, 64, 0, 0, 0));
		send_beat(make_req(OP_EDIT, 1, 64, 0, 0, '1));
		send_beat(make_req(OP_QUERY, 64, 1, 0, 0, 0));
		send_beat(make_req(OP_QUERY, 0, 1, 0, 0, 0));
		send_beat(make_req(OP_QUERY, 1, 65, 0, 0, 0));
		send_beat(make_req(OP_QUERY, 1, 3, 0, 0, 0));
		send_beat(make_req(OP_REMOVE, 3, 0, 0, 0, 0));
		send_beat(make_req(OP_REMOVE, 0, 0, 0, 0, 0));
		send_beat(make_req(OP_REMOVE, 64, 0, 0, 0, 0));
		send_beat(make_req(OP_QUERY, 1, 64, 0, 0, 0));
		send_beat(make_req(OP_ADD, 64, 0, 24'h800000, 1, 0));
		send_beat(make_req(OP_QUERY, 64, 1, 0, 0, 0));

		// Random part in four idling phases.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			repeat (480) send_beat(random_req());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		$display("Covered %0d request beats: all four operations and every status,", sent_beats);
		$display("under no idling, sender gaps, receiver stalls and both together.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Timeout for a hung run; successful adds, which walk every vertex slot, are the slowest requests.
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/edmg_pkg.sv
rtl/edmg_ctrl.sv
rtl/edmg_sqrt.sv
rtl/edmg_dp.sv
rtl/euclidean_distance_matrix_graph_unit.sv
rtl/edmg_checker.sv
tb/euclidean_distance_matrix_graph_unit_checker.sv
tb/euclidean_distance_matrix_graph_unit_tb.sv
